@@ hw/rtl/sfcr_pkg.sv @@
// ----------------------------------------------------------------------------
// sfcr_pkg
// Shared types and byte codes of the stuffed frame command receiver.
// ----------------------------------------------------------------------------
package sfcr_pkg;

    // framing bytes
    localparam logic [7:0] BYTE_SOF   = 8'h01;
    localparam logic [7:0] BYTE_ESC   = 8'h10;
    localparam logic [7:0] BYTE_EOF   = 8'h04;
    localparam logic [7:0] ESC_OFFSET = 8'h20;

    // message types
    localparam logic [7:0] MSG_WRITE = 8'h00;
    localparam logic [7:0] MSG_READ  = 8'h01;

    // command codes
    localparam logic [15:0] CMD_INFO     = 16'h0000;
    localparam logic [15:0] CMD_MASK_SET = 16'h0004;
    localparam logic [15:0] CMD_MASK_OR  = 16'h0005;
    localparam logic [15:0] CMD_MASK_CLR = 16'h0006;
    localparam logic [15:0] CMD_BUZZER   = 16'h0010;

    // header bytes kept after the start byte, and the smallest legal frame
    localparam int HDR_BYTES = 7;
    localparam int MIN_LEN   = 7;
    localparam int LEN_ADJ   = 4;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SHORT    = 2'd1,
        ST_LEN_ERR  = 2'd2,
        ST_OVERFLOW = 2'd3
    } sfcr_status_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_MASK_SET,
        OP_MASK_OR,
        OP_MASK_CLR,
        OP_BUZZER
    } sfcr_op_t;

    // one classified frame, handed from the front to the back
    typedef struct packed {
        sfcr_status_t status;
        logic [7:0]   msg_type;
        logic [15:0]  command;
        logic [10:0]  data_count;
        sfcr_op_t     op;
        logic [15:0]  word;
        logic         info;
    } sfcr_frame_t;

endpackage

@@ hw/rtl/sfcr_if.sv @@
// ----------------------------------------------------------------------------
// sfcr interfaces
// Valid/ready channels for received bytes and frame status results.
// ----------------------------------------------------------------------------
interface sfcr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfcr_status_if;
    logic        valid;
    logic        ready;
    logic [1:0]  frame_status;
    logic [7:0]  msg_type;
    logic [15:0] command;
    logic [10:0] data_count;
    logic [15:0] debug_mask;
    logic [7:0]  buzzer_setting;
    logic        info_requested;

    modport source (
        output valid, output frame_status, output msg_type, output command,
        output data_count, output debug_mask, output buzzer_setting,
        output info_requested, input ready
    );
    modport sink (
        input valid, input frame_status, input msg_type, input command,
        input data_count, input debug_mask, input buzzer_setting,
        input info_requested, output ready
    );
endinterface

@@ hw/rtl/sfcr_queue.sv @@
// ----------------------------------------------------------------------------
// sfcr_queue
// Two-entry queue of classified frames between the front and the back.
// ----------------------------------------------------------------------------
module sfcr_queue
    import sfcr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  sfcr_frame_t push_data,
    output logic        full,
    input  logic        pop,
    output logic        not_empty,
    output sfcr_frame_t pop_data
);

    sfcr_frame_t mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        do_push, do_pop;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        cnt_next    = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hw/rtl/sfcr_front.sv @@
// ----------------------------------------------------------------------------
// sfcr_front
// Byte deframer: hunts the start byte, removes escapes, captures the header
// and classifies the frame when the end byte arrives.
// ----------------------------------------------------------------------------
module sfcr_front
    import sfcr_pkg::*;
#(
    parameter int MAX_FRAME = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    sfcr_rx_if.sink     rx,
    input  logic        full,
    output logic        push,
    output sfcr_frame_t frame
);

    localparam int CW = $clog2(MAX_FRAME + 1);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_FRAME);

    typedef enum logic [1:0] {
        M_IDLE,
        M_RECV,
        M_UNSTUFF
    } mode_t;

    mode_t         mode_reg, mode_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [7:0]    hdr_reg [HDR_BYTES];

    logic          accept;
    logic          store_en;
    logic [7:0]    store_val;
    logic          at_max;
    logic          hdr_wr;
    logic [2:0]    hdr_idx;
    logic [16:0]   len;
    logic [15:0]   field;

    assign rx.ready = !full;
    assign accept   = rx.valid && rx.ready;
    assign at_max   = (count_reg >= MAX_C);
    assign hdr_wr   = store_en && !at_max && (count_reg >= CW'(1))
                      && (count_reg <= CW'(HDR_BYTES));
    assign hdr_idx  = 3'(count_reg - CW'(1));

    always_comb
    begin
        mode_next  = mode_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        store_en   = 1'b0;
        store_val  = rx.rx_byte;
        push       = 1'b0;
        if (accept)
        begin
            unique case (mode_reg)
                M_UNSTUFF:
                begin
                    store_en  = 1'b1;
                    store_val = rx.rx_byte - ESC_OFFSET;
                    mode_next = M_RECV;
                end
                M_RECV:
                begin
                    if (rx.rx_byte == BYTE_SOF)
                    begin
                        mode_next  = M_RECV;
                        count_next = CW'(1);
                        ovf_next   = 1'b0;
                    end
                    else if (rx.rx_byte == BYTE_ESC)
                    begin
                        mode_next = M_UNSTUFF;
                    end
                    else if (rx.rx_byte == BYTE_EOF)
                    begin
                        store_en  = 1'b1;
                        push      = 1'b1;
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        store_en = 1'b1;
                    end
                end
                M_IDLE:
                begin
                    if (rx.rx_byte == BYTE_SOF)
                    begin
                        mode_next  = M_RECV;
                        count_next = CW'(1);
                        ovf_next   = 1'b0;
                    end
                end
                default:
                begin
                    mode_next = M_IDLE;
                end
            endcase
            if (store_en)
            begin
                if (at_max)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                end
            end
        end
    end

    // classification of the frame closed by the end byte
    assign len   = 17'(count_reg) + 17'd1;
    assign field = {hdr_reg[0], hdr_reg[1]};

    always_comb
    begin
        frame            = '0;
        frame.status     = ST_OK;
        frame.op         = OP_NONE;
        if (ovf_reg || at_max)
        begin
            frame.status = ST_OVERFLOW;
        end
        else if (len < 17'(MIN_LEN))
        begin
            frame.status = ST_SHORT;
        end
        else
        begin
            frame.msg_type = hdr_reg[2];
            frame.command  = {hdr_reg[3], hdr_reg[4]};
            if (17'(field) != len - 17'(LEN_ADJ))
            begin
                frame.status = ST_LEN_ERR;
            end
            else
            begin
                frame.data_count = 11'(len - 17'(MIN_LEN));
                frame.word       = {hdr_reg[5], hdr_reg[6]};
                if (hdr_reg[2] == MSG_WRITE)
                begin
                    if (frame.command == CMD_MASK_SET && len >= 17'(MIN_LEN + 2))
                    begin
                        frame.op = OP_MASK_SET;
                    end
                    else if (frame.command == CMD_MASK_OR && len >= 17'(MIN_LEN + 2))
                    begin
                        frame.op = OP_MASK_OR;
                    end
                    else if (frame.command == CMD_MASK_CLR && len >= 17'(MIN_LEN + 2))
                    begin
                        frame.op = OP_MASK_CLR;
                    end
                    else if (frame.command == CMD_BUZZER && len >= 17'(MIN_LEN + 1))
                    begin
                        frame.op = OP_BUZZER;
                    end
                end
                else if (hdr_reg[2] == MSG_READ && frame.command == CMD_INFO)
                begin
                    frame.info = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hdr_wr)
        begin
            hdr_reg[hdr_idx] <= store_val;
        end
    end

endmodule

@@ hw/rtl/sfcr_back.sv @@
// ----------------------------------------------------------------------------
// sfcr_back
// Applies write commands to the debug mask and buzzer byte and holds the
// status result until it is taken.
// ----------------------------------------------------------------------------
module sfcr_back
    import sfcr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  sfcr_frame_t   q_data,
    output logic          pop,
    sfcr_status_if.source stat
);

    logic        out_valid_reg, out_valid_next;
    logic [15:0] mask_reg, mask_next;
    logic [7:0]  buzz_reg, buzz_next;

    logic [1:0]  status_reg;
    logic [7:0]  type_reg;
    logic [15:0] cmd_reg;
    logic [10:0] dcount_reg;
    logic [15:0] mask_out_reg;
    logic [7:0]  buzz_out_reg;
    logic        info_reg;

    assign pop = q_valid && (!out_valid_reg || stat.ready);

    always_comb
    begin
        mask_next      = mask_reg;
        buzz_next      = buzz_reg;
        out_valid_next = out_valid_reg && !stat.ready;
        if (pop)
        begin
            out_valid_next = 1'b1;
            unique case (q_data.op)
                OP_MASK_SET: mask_next = q_data.word;
                OP_MASK_OR:  mask_next = mask_reg | q_data.word;
                OP_MASK_CLR: mask_next = mask_reg & ~q_data.word;
                OP_BUZZER:   buzz_next = q_data.word[15:8];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            mask_reg      <= '0;
            buzz_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            mask_reg      <= mask_next;
            buzz_reg      <= buzz_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg   <= q_data.status;
            type_reg     <= q_data.msg_type;
            cmd_reg      <= q_data.command;
            dcount_reg   <= q_data.data_count;
            mask_out_reg <= mask_next;
            buzz_out_reg <= buzz_next;
            info_reg     <= q_data.info;
        end
    end

    assign stat.valid          = out_valid_reg;
    assign stat.frame_status   = status_reg;
    assign stat.msg_type       = type_reg;
    assign stat.command        = cmd_reg;
    assign stat.data_count     = dcount_reg;
    assign stat.debug_mask     = mask_out_reg;
    assign stat.buzzer_setting = buzz_out_reg;
    assign stat.info_requested = info_reg;

endmodule

@@ hw/rtl/stuffed_frame_command_receiver.sv @@
// ----------------------------------------------------------------------------
// stuffed_frame_command_receiver
// The end byte pushes the frame into the queue; the status transaction is registered when the back pops it.
// Throughput: one byte per cycle; rx.ready drops only when the 2-entry frame
// queue is full because status transactions are not being taken.
// Reset: deframer idle, queue empty, debug mask and buzzer byte cleared.
// ----------------------------------------------------------------------------
module stuffed_frame_command_receiver
    import sfcr_pkg::*;
#(
    parameter int MAX_FRAME = 1024
)
(
    input  logic          clk,
    input  logic          rst_n,
    sfcr_rx_if.sink       rx,
    sfcr_status_if.source stat
);

    logic        push;
    logic        full;
    logic        pop;
    logic        q_valid;
    sfcr_frame_t push_data;
    sfcr_frame_t q_data;

    sfcr_front #(
        .MAX_FRAME (MAX_FRAME)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .full  (full),
        .push  (push),
        .frame (push_data)
    );

    sfcr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .not_empty (q_valid),
        .pop_data  (q_data)
    );

    sfcr_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_data),
        .pop     (pop),
        .stat    (stat)
    );

endmodule

@@ hw/rtl/sfcr_checker.sv @@
// ----------------------------------------------------------------------------
// sfcr_checker
// Port-level checks of the status channel, bound to the top level.
// ----------------------------------------------------------------------------
module sfcr_checker
    import sfcr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  frame_status,
    input logic [7:0]  msg_type,
    input logic [15:0] command,
    input logic [10:0] data_count,
    input logic [15:0] debug_mask,
    input logic [7:0]  buzzer_setting,
    input logic        info_requested
);

    // stalled transaction holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(frame_status)
        && $stable(command) && $stable(debug_mask) && $stable(buzzer_setting))
        else $error("status transaction changed while stalled");

    // a failed frame reports no data and no info request
    a_fail_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_status != ST_OK |-> data_count == 11'd0
        && !info_requested)
        else $error("failed frame carries data count or info request");

    // short and overflow frames carry no header
    a_no_header: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (frame_status == ST_SHORT || frame_status == ST_OVERFLOW)
        |-> msg_type == 8'd0 && command == 16'd0)
        else $error("header reported for short or overflow frame");

    // info request only for a good read of the info command
    a_info: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && info_requested |-> frame_status == ST_OK
        && msg_type == MSG_READ && command == CMD_INFO)
        else $error("info request on wrong frame");

endmodule

bind stuffed_frame_command_receiver sfcr_checker u_sfcr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (stat.valid),
    .out_ready      (stat.ready),
    .frame_status   (stat.frame_status),
    .msg_type       (stat.msg_type),
    .command        (stat.command),
    .data_count     (stat.data_count),
    .debug_mask     (stat.debug_mask),
    .buzzer_setting (stat.buzzer_setting),
    .info_requested (stat.info_requested)
);
